@@ design/hvd_pkg.sv @@
package hvd_pkg;

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [30:0] PH_QUARTER = 31'h4000_0000;
    localparam logic [30:0] PH_EIGHTH = 31'h2000_0000;
    localparam logic [32:0] PI_Q31 = 33'h1_921F_B544;
    localparam logic [31:0] DEG_K = 32'd3054198966;
    localparam logic [31:0] DIST_MUL = 32'd3261952000;
    localparam logic [64:0] DIST_HALF = 65'd1609 << 29;
    localparam logic [10:0] MILE_DIV = 11'd1609;
    localparam logic [29:0] MILE_RECIP = 30'((64'd1 << 40) / 64'd1609);
    localparam logic [21:0] DIST_MAX = 22'd3184640;

    localparam int NITER = 7;
    localparam int HORNER_LAT = 6;
    localparam int TRIG_LAT = 1 + 2 + NITER * HORNER_LAT + 2 + 2;
    localparam int STEP_LAT = TRIG_LAT + 1;
    localparam int SEARCH_STEPS = 30;
    localparam int PIPE_LAT = 2 + TRIG_LAT + 4 + 1 + SEARCH_STEPS * STEP_LAT + 7;

    localparam logic [7:0] SIN_DEN [0:6] = '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DEN [0:6] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    localparam logic [61:0] SIN_RCP [0:6] = '{
        62'((64'd1 << 62) / 64'd210), 62'((64'd1 << 62) / 64'd156),
        62'((64'd1 << 62) / 64'd110), 62'((64'd1 << 62) / 64'd72),
        62'((64'd1 << 62) / 64'd42), 62'((64'd1 << 62) / 64'd20),
        62'((64'd1 << 62) / 64'd6)};
    localparam logic [61:0] COS_RCP [0:6] = '{
        62'((64'd1 << 62) / 64'd182), 62'((64'd1 << 62) / 64'd132),
        62'((64'd1 << 62) / 64'd90), 62'((64'd1 << 62) / 64'd56),
        62'((64'd1 << 62) / 64'd30), 62'((64'd1 << 62) / 64'd12),
        62'((64'd1 << 62) / 64'd2)};

    typedef struct packed {
        logic [62:0] x;
        logic [63:0] x2;
        logic        wc;
        logic        neg;
    } trig_side_t;

endpackage

@@ design/hvd_mul64.sv @@
module hvd_mul64 (
    input  logic         aclk,
    input  logic         ce,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod
);
    logic [63:0]  pp_reg [4];
    logic [127:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            pp_reg[0] <= a[31:0] * b[31:0];
            pp_reg[1] <= a[31:0] * b[63:32];
            pp_reg[2] <= a[63:32] * b[31:0];
            pp_reg[3] <= a[63:32] * b[63:32];
            prod_reg  <= {pp_reg[3], pp_reg[0]} + {32'b0, pp_reg[1], 32'b0}
                         + {32'b0, pp_reg[2], 32'b0};
        end
    end

    assign prod = prod_reg;

endmodule

@@ design/hvd_horner.sv @@
module hvd_horner (
    input  logic                aclk,
    input  logic                ce,
    input  logic [2:0]          iter,
    input  hvd_pkg::trig_side_t side_in,
    input  logic [63:0]         t_in,
    output hvd_pkg::trig_side_t side_out,
    output logic [63:0]         t_out
);
    import hvd_pkg::*;

    trig_side_t   side_reg [6];
    logic [63:0]  n_reg [3];
    logic [63:0]  qe_reg;
    logic [63:0]  qd_reg;
    logic [63:0]  t_reg;
    logic [127:0] pa;
    logic [127:0] pb;
    logic [63:0]  n_next;
    logic [63:0]  qe_next;
    logic [63:0]  r_next;
    logic [61:0]  rcp;
    logic [7:0]   den_q;
    logic [7:0]   den_r;

    hvd_mul64 u_mul_a (.aclk, .ce, .a(side_in.x2), .b(t_in), .prod(pa));

    assign n_next = pa[125:62];
    assign rcp    = side_reg[1].wc ? COS_RCP[iter] : SIN_RCP[iter];

    hvd_mul64 u_mul_b (.aclk, .ce, .a(n_next), .b({2'b00, rcp}), .prod(pb));

    assign qe_next = pb[125:62];
    assign den_q   = side_reg[3].wc ? COS_DEN[iter] : SIN_DEN[iter];
    assign den_r   = side_reg[4].wc ? COS_DEN[iter] : SIN_DEN[iter];
    assign r_next  = n_reg[2] - qd_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < 6; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            n_reg[0] <= n_next;
            n_reg[1] <= n_reg[0];
            n_reg[2] <= n_reg[1];
            qe_reg   <= qe_next;
            qd_reg   <= qe_next * {56'b0, den_q};
            t_reg    <= ONE_Q62 - ((r_next >= {56'b0, den_r}) ? (qe_reg + 64'd1) : qe_reg);
        end
    end

    assign side_out = side_reg[5];
    assign t_out    = t_reg;

endmodule

@@ design/hvd_trig.sv @@
module hvd_trig (
    input  logic        aclk,
    input  logic        ce,
    input  logic [31:0] phase,
    output logic [63:0] mag,
    output logic        neg,
    output logic [63:0] sq
);
    import hvd_pkg::*;

    logic [30:0]  u_w;
    logic [29:0]  uu_w;
    logic         wc_w;
    logic [62:0]  x_w;
    logic [62:0]  x_reg;
    logic         wc_reg;
    logic         neg_reg;
    trig_side_t   s0_reg [2];
    logic [127:0] px;
    logic [127:0] pm;
    logic [127:0] psq;
    trig_side_t   side_ch [0:7];
    logic [63:0]  t_ch [0:7];
    logic [63:0]  mag_w;
    logic [63:0]  mag_d [2];
    logic         neg_d [4];

    assign u_w  = phase[30] ? (PH_QUARTER - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    assign wc_w = u_w > PH_EIGHTH;
    assign uu_w = wc_w ? 30'(PH_QUARTER - u_w) : u_w[29:0];
    assign x_w  = uu_w * PI_Q31;

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg     <= x_w;
            wc_reg    <= wc_w;
            neg_reg   <= phase[31];
            s0_reg[0] <= '{x: x_reg, x2: 64'b0, wc: wc_reg, neg: neg_reg};
            s0_reg[1] <= s0_reg[0];
        end
    end

    hvd_mul64 u_mul_x (.aclk, .ce, .a({1'b0, x_reg}), .b({1'b0, x_reg}), .prod(px));

    assign side_ch[0] = '{x: s0_reg[1].x, x2: px[125:62], wc: s0_reg[1].wc,
                          neg: s0_reg[1].neg};
    assign t_ch[0]    = ONE_Q62;

    for (genvar j = 0; j < NITER; j++) begin : g_iter
        hvd_horner u_horner (
            .aclk, .ce, .iter(3'(j)),
            .side_in(side_ch[j]), .t_in(t_ch[j]),
            .side_out(side_ch[j+1]), .t_out(t_ch[j+1])
        );
    end

    hvd_mul64 u_mul_m (
        .aclk, .ce,
        .a(side_ch[NITER].wc ? ONE_Q62 : {1'b0, side_ch[NITER].x}),
        .b(t_ch[NITER]), .prod(pm)
    );

    assign mag_w = pm[125:62];

    hvd_mul64 u_mul_sq (.aclk, .ce, .a(mag_w), .b(mag_w), .prod(psq));

    always_ff @(posedge aclk) begin
        if (ce) begin
            mag_d[0] <= mag_w;
            mag_d[1] <= mag_d[0];
            neg_d[0] <= side_ch[NITER].neg;
            for (int k = 1; k < 4; k++) begin
                neg_d[k] <= neg_d[k-1];
            end
        end
    end

    assign mag = mag_d[1];
    assign neg = neg_d[3];
    assign sq  = psq[125:62];

endmodule

@@ design/hvd_search_step.sv @@
module hvd_search_step (
    input  logic        aclk,
    input  logic        ce,
    input  logic [4:0]  bit_idx,
    input  logic [62:0] a_in,
    input  logic [29:0] p_in,
    output logic [62:0] a_out,
    output logic [29:0] p_out
);
    import hvd_pkg::*;

    logic [29:0] cand_w;
    logic [29:0] bit_mask;
    logic [63:0] sq;
    logic [62:0] a_d [TRIG_LAT];
    logic [29:0] cand_d [TRIG_LAT];
    logic [62:0] a_reg;
    logic [29:0] p_reg;

    assign bit_mask = 30'd1 << bit_idx;
    assign cand_w   = p_in | bit_mask;

    hvd_trig u_trig (.aclk, .ce, .phase({2'b00, cand_w}), .mag(), .neg(), .sq(sq));

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_d[0]    <= a_in;
            cand_d[0] <= cand_w;
            for (int k = 1; k < TRIG_LAT; k++) begin
                a_d[k]    <= a_d[k-1];
                cand_d[k] <= cand_d[k-1];
            end
            a_reg <= a_d[TRIG_LAT-1];
            p_reg <= (sq <= {1'b0, a_d[TRIG_LAT-1]}) ? cand_d[TRIG_LAT-1]
                                                     : (cand_d[TRIG_LAT-1] & ~bit_mask);
        end
    end

    assign a_out = a_reg;
    assign p_out = p_reg;

endmodule

@@ design/haversine_distance_miles_top.sv @@
// Channel  Direction  Payload
// s_       in         tdata[23:0] point_latitude, tdata[48:24] point_longitude
// m_       out        tdata[21:0] distance_miles
// cfg_     in         index 0 ref_latitude, index 1 ref_longitude (data[24:0])
//
// One point is accepted per cycle while the skid register is empty.
// Most of the pipeline depth lies in thirty chained sine evaluations.
// Reset is synchronous and active low; it clears the reference point and all valid bits.
// A stalled output fills a one-entry skid register, after which the pipeline holds.
module haversine_distance_miles_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // point_latitude[23:0], point_longitude[48:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // distance_miles[21:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);
    import hvd_pkg::*;

    localparam logic CFG_LAT = 1'b0;
    localparam logic CFG_LNG = 1'b1;

    logic                  ce;
    logic [PIPE_LAT-1:0]   vld_reg;
    logic signed [23:0]    ref_lat_reg;
    logic signed [24:0]    ref_lng_reg;
    logic signed [24:0]    dlat_reg;
    logic signed [25:0]    dlng_reg;
    logic signed [23:0]    lat1_reg;
    logic signed [23:0]    lat2_reg;
    logic signed [57:0]    pr_dlat;
    logic signed [58:0]    pr_dlng;
    logic signed [56:0]    pr_lat1;
    logic signed [56:0]    pr_lat2;
    logic [31:0]           ph_s1_reg;
    logic [31:0]           ph_s2_reg;
    logic [31:0]           ph_c1_reg;
    logic [31:0]           ph_c2_reg;
    logic [63:0]           s1sq;
    logic [63:0]           s2sq;
    logic [63:0]           c1mag;
    logic [63:0]           c2mag;
    logic                  n1;
    logic                  n2;
    logic [127:0]          pc1;
    logic [127:0]          pc2;
    logic [63:0]           c2_d [2];
    logic [63:0]           s1_d [4];
    logic                  nx_d [4];
    logic [63:0]           prod_w;
    logic [64:0]           a_pre;
    logic [62:0]           a_reg;
    logic [62:0]           a_ch [0:SEARCH_STEPS];
    logic [29:0]           p_ch [0:SEARCH_STEPS];
    logic [30:0]           p_fin;
    logic [63:0]           h62_reg;
    logic [127:0]          pdist;
    logic [64:0]           m_sum;
    logic [32:0]           y30_reg;
    logic [32:0]           y30b_reg;
    logic [32:0]           y30c_reg;
    logic [62:0]           yq;
    logic [21:0]           qe_reg;
    logic [21:0]           qe2_reg;
    logic [32:0]           qd_reg;
    logic [32:0]           rem_w;
    logic [21:0]           dist_reg;
    logic                  m_tvalid_reg;
    logic [21:0]           m_data_reg;
    logic                  skid_vld_reg;
    logic [21:0]           skid_data_reg;
    logic                  out_free;

    assign ce        = !skid_vld_reg;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_lat_reg <= '0;
            ref_lng_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LAT: ref_lat_reg <= cfg_data[23:0];
                CFG_LNG: ref_lng_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    assign pr_dlat = dlat_reg * $signed({1'b0, DEG_K});
    assign pr_dlng = dlng_reg * $signed({1'b0, DEG_K});
    assign pr_lat1 = lat1_reg * $signed({1'b0, DEG_K});
    assign pr_lat2 = lat2_reg * $signed({1'b0, DEG_K});

    always_ff @(posedge aclk) begin
        if (ce) begin
            dlat_reg  <= $signed({s_tdata[23], s_tdata[23:0]})
                         - $signed({ref_lat_reg[23], ref_lat_reg});
            dlng_reg  <= $signed({s_tdata[48], s_tdata[48:24]})
                         - $signed({ref_lng_reg[24], ref_lng_reg});
            lat1_reg  <= ref_lat_reg;
            lat2_reg  <= s_tdata[23:0];
            ph_s1_reg <= pr_dlat[56:25];
            ph_s2_reg <= pr_dlng[56:25];
            ph_c1_reg <= pr_lat1[55:24] + {1'b0, PH_QUARTER};
            ph_c2_reg <= pr_lat2[55:24] + {1'b0, PH_QUARTER};
        end
    end

    hvd_trig u_trig_s1 (.aclk, .ce, .phase(ph_s1_reg), .mag(), .neg(), .sq(s1sq));
    hvd_trig u_trig_s2 (.aclk, .ce, .phase(ph_s2_reg), .mag(), .neg(), .sq(s2sq));
    hvd_trig u_trig_c1 (.aclk, .ce, .phase(ph_c1_reg), .mag(c1mag), .neg(n1), .sq());
    hvd_trig u_trig_c2 (.aclk, .ce, .phase(ph_c2_reg), .mag(c2mag), .neg(n2), .sq());

    hvd_mul64 u_mul_c1 (.aclk, .ce, .a(s2sq), .b(c1mag), .prod(pc1));
    hvd_mul64 u_mul_c2 (.aclk, .ce, .a(pc1[125:62]), .b(c2_d[1]), .prod(pc2));

    assign prod_w = pc2[125:62];

    always_comb begin
        if (nx_d[3]) begin
            a_pre = (s1_d[3] >= prod_w) ? {1'b0, s1_d[3] - prod_w} : 65'd0;
        end else begin
            a_pre = {1'b0, s1_d[3]} + {1'b0, prod_w};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c2_d[0] <= c2mag;
            c2_d[1] <= c2_d[0];
            s1_d[0] <= s1sq;
            nx_d[0] <= n1 ^ n2;
            for (int k = 1; k < 4; k++) begin
                s1_d[k] <= s1_d[k-1];
                nx_d[k] <= nx_d[k-1];
            end
            a_reg <= (a_pre > {1'b0, ONE_Q62}) ? ONE_Q62[62:0] : a_pre[62:0];
        end
    end

    assign a_ch[0] = a_reg;
    assign p_ch[0] = '0;

    for (genvar i = 0; i < SEARCH_STEPS; i++) begin : g_search
        hvd_search_step u_step (
            .aclk, .ce, .bit_idx(5'(SEARCH_STEPS - 1 - i)),
            .a_in(a_ch[i]), .p_in(p_ch[i]),
            .a_out(a_ch[i+1]), .p_out(p_ch[i+1])
        );
    end

    assign p_fin = (a_ch[SEARCH_STEPS] == ONE_Q62[62:0]) ? PH_QUARTER
                                                         : {1'b0, p_ch[SEARCH_STEPS]};

    hvd_mul64 u_mul_dist (.aclk, .ce, .a(h62_reg), .b({32'b0, DIST_MUL}), .prod(pdist));

    assign m_sum = {1'b0, pdist[95:32]} + DIST_HALF;
    assign yq    = y30_reg * MILE_RECIP;
    assign rem_w = y30c_reg - qd_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            h62_reg  <= p_fin * PI_Q31;
            y30_reg  <= m_sum[62:30];
            qe_reg   <= yq[61:40];
            y30b_reg <= y30_reg;
            qd_reg   <= qe_reg * MILE_DIV;
            qe2_reg  <= qe_reg;
            y30c_reg <= y30b_reg;
            dist_reg <= (rem_w >= {22'b0, MILE_DIV}) ? (qe2_reg + 22'd1) : qe2_reg;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[PIPE_LAT-1]) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (out_free) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (vld_reg[PIPE_LAT-1]) begin
            if (out_free) begin
                m_data_reg <= dist_reg;
            end else begin
                skid_data_reg <= dist_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid register filled without a stalled output");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_data_reg <= DIST_MAX)
        else $error("distance beyond a half turn");

endmodule
